### src/gis_pkg.sv
`timescale 1ns / 1ps
// Shared package of the gray image scaler: field widths, register indexes,
// reset values, controller/datapath command and status types, and the color mapping.
// No dependencies.
package gis_pkg;

    localparam int STORE_DEPTH_DEF    = 32768;
    localparam int MAX_SHOWN_SIDE_DEF = 240;

    localparam int GRAY_W     = 8;
    localparam int STORE_AW   = 15;
    localparam int IN_TDATA_W = 24;
    localparam int PIX_W      = 16;
    localparam int SRC_W_W    = 9;
    localparam int SIDE_W     = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 9;

    localparam int DIVIDEND_W = 18;
    localparam int RADIX_BITS = 2;
    localparam int ROWQ_W     = 16;
    localparam int COLQ_W     = 17;
    localparam int PROD_W     = ROWQ_W + SRC_W_W;
    localparam int ADDR_W     = PROD_W + 1;

    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_FETCH = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_WIDTH   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_HEIGHT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SHOWN_WIDTH    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SHOWN_HEIGHT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BINARIZE_LEVEL = 3'd4;

    localparam logic [SRC_W_W-1:0] SOURCE_WIDTH_RST   = 9'd188;
    localparam logic [SIDE_W-1:0]  SOURCE_HEIGHT_RST  = 8'd120;
    localparam logic [SIDE_W-1:0]  SHOWN_WIDTH_RST    = 8'd160;
    localparam logic [SIDE_W-1:0]  SHOWN_HEIGHT_RST   = 8'd80;
    localparam logic [GRAY_W-1:0]  BINARIZE_LEVEL_RST = 8'd0;

    localparam logic [PIX_W-1:0] RED_BLUE_MASK = 16'h001f;
    localparam logic [PIX_W-1:0] GREEN_MASK    = 16'h003f;
    localparam logic [PIX_W-1:0] COLOR_WHITE   = 16'hffff;
    localparam logic [PIX_W-1:0] COLOR_BLACK   = 16'h0000;

    typedef struct packed {
        logic wr;
        logic capture;
        logic div_step;
        logic addr_calc;
        logic mem_rd;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic fetch_req;
    } t_dp_sts;

    function automatic logic [PIX_W-1:0] to_color(input logic [GRAY_W-1:0] g,
                                                  input logic [GRAY_W-1:0] level);
        logic [PIX_W-1:0] g_ext;
        logic [PIX_W-1:0] c;
        g_ext = PIX_W'(g);
        if (level == '0) begin
            c = ((RED_BLUE_MASK & (g_ext >> 3)) << 11)
              | ((GREEN_MASK & (g_ext >> 2)) << 5)
              | (RED_BLUE_MASK & (g_ext >> 3));
        end else if (g < level) begin
            c = COLOR_BLACK;
        end else begin
            c = COLOR_WHITE;
        end
        return c;
    endfunction

endpackage

### src/gis_div.sv
`timescale 1ns / 1ps
// Radix-4 restoring divider lane of the gray image scaler, two quotient bits per step.
// Depends on gis_pkg.
module gis_div (
    input  logic                               i_clk,
    input  logic                               i_load,
    input  logic                               i_step,
    input  logic [gis_pkg::DIVIDEND_W-1:0]     i_dividend,
    input  logic [gis_pkg::SIDE_W-1:0]         i_divisor,
    output logic [gis_pkg::DIVIDEND_W-1:0]     o_quotient
);

    logic [gis_pkg::SIDE_W-1:0]     r_rem;
    logic [gis_pkg::SIDE_W-1:0]     n_rem;
    logic [gis_pkg::DIVIDEND_W-1:0] r_quo;
    logic [gis_pkg::DIVIDEND_W-1:0] n_quo;
    logic [gis_pkg::SIDE_W-1:0]     r_div;
    logic [gis_pkg::SIDE_W:0]       w_trial;

    always_comb begin
        n_rem   = r_rem;
        n_quo   = r_quo;
        w_trial = '0;
        for (int k = 0; k < gis_pkg::RADIX_BITS; k++) begin
            w_trial = {n_rem, n_quo[gis_pkg::DIVIDEND_W-1]};
            if (w_trial >= {1'b0, r_div}) begin
                n_rem = gis_pkg::SIDE_W'(w_trial - {1'b0, r_div});
                n_quo = {n_quo[gis_pkg::DIVIDEND_W-2:0], 1'b1};
            end else begin
                n_rem = w_trial[gis_pkg::SIDE_W-1:0];
                n_quo = {n_quo[gis_pkg::DIVIDEND_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_div <= i_divisor;
        end else if (i_step) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_quotient = r_quo;

endmodule

### src/gis_datapath.sv
`timescale 1ns / 1ps
// Datapath of the gray image scaler: configuration registers, display counters,
// two divider lanes, source address multiply, frame store and output register.
// Depends on gis_pkg and gis_div.
module gis_datapath #(
    parameter int STORE_DEPTH    = gis_pkg::STORE_DEPTH_DEF,
    parameter int MAX_SHOWN_SIDE = gis_pkg::MAX_SHOWN_SIDE_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  gis_pkg::t_dp_cmd                   i_cmd,
    output gis_pkg::t_dp_sts                   o_sts,
    input  logic [gis_pkg::IN_TDATA_W-1:0]     i_s_tdata,
    input  logic                               i_s_tuser,
    input  logic                               i_cfg_wr_en,
    input  logic [gis_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [gis_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output logic [gis_pkg::PIX_W-1:0]          o_m_tdata,
    output logic                               o_m_tlast
);

    localparam int MEM_AW = $clog2(STORE_DEPTH);

    logic [gis_pkg::SRC_W_W-1:0] r_src_w;
    logic [gis_pkg::SIDE_W-1:0]  r_src_h;
    logic [gis_pkg::SIDE_W-1:0]  r_shown_w;
    logic [gis_pkg::SIDE_W-1:0]  r_shown_h;
    logic [gis_pkg::GRAY_W-1:0]  r_level;

    logic [gis_pkg::SIDE_W-1:0]  r_col;
    logic [gis_pkg::SIDE_W-1:0]  r_row;
    logic [gis_pkg::SIDE_W-1:0]  n_col;
    logic [gis_pkg::SIDE_W-1:0]  n_row;
    logic                        n_last;
    logic                        r_last;

    logic [gis_pkg::SIDE_W-1:0]  w_eff_w;
    logic [gis_pkg::SIDE_W-1:0]  w_eff_h;
    logic [gis_pkg::DIVIDEND_W-1:0] w_row_prod;
    logic [gis_pkg::DIVIDEND_W-1:0] w_col_prod;
    logic [gis_pkg::DIVIDEND_W-1:0] w_row_quo;
    logic [gis_pkg::DIVIDEND_W-1:0] w_col_quo;
    logic [gis_pkg::PROD_W-1:0]     w_addr_prod;
    logic [gis_pkg::ADDR_W-1:0]     r_addr;
    logic [gis_pkg::ADDR_W-1:0]     w_wr_addr;

    logic [gis_pkg::GRAY_W-1:0]  r_mem [STORE_DEPTH];
    logic [gis_pkg::GRAY_W-1:0]  r_rd_data;
    logic                        r_rd_oob;
    logic [gis_pkg::PIX_W-1:0]   r_pixel;
    logic                        r_frame_end;

    function automatic logic [gis_pkg::SIDE_W-1:0] eff_side(
        input logic [gis_pkg::SIDE_W-1:0] v
    );
        logic [gis_pkg::SIDE_W-1:0] e;
        if (v == '0) begin
            e = gis_pkg::SIDE_W'(1);
        end else if (32'(v) > 32'(MAX_SHOWN_SIDE)) begin
            e = gis_pkg::SIDE_W'(MAX_SHOWN_SIDE);
        end else begin
            e = v;
        end
        return e;
    endfunction

    assign o_sts.fetch_req = (i_s_tuser == gis_pkg::REQ_FETCH);

    assign w_eff_w    = eff_side(r_shown_w);
    assign w_eff_h    = eff_side(r_shown_h);
    assign w_row_prod = gis_pkg::DIVIDEND_W'(r_row) * gis_pkg::DIVIDEND_W'(r_src_h);
    assign w_col_prod = gis_pkg::DIVIDEND_W'(r_col) * gis_pkg::DIVIDEND_W'(r_src_w);

    always_comb begin
        n_col  = r_col;
        n_row  = r_row;
        n_last = 1'b0;
        if ({1'b0, r_col} + 9'd1 >= {1'b0, w_eff_w}) begin
            n_col = '0;
            if ({1'b0, r_row} + 9'd1 >= {1'b0, w_eff_h}) begin
                n_row  = '0;
                n_last = 1'b1;
            end else begin
                n_row = r_row + 8'd1;
            end
        end else begin
            n_col = r_col + 8'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_w   <= gis_pkg::SOURCE_WIDTH_RST;
            r_src_h   <= gis_pkg::SOURCE_HEIGHT_RST;
            r_shown_w <= gis_pkg::SHOWN_WIDTH_RST;
            r_shown_h <= gis_pkg::SHOWN_HEIGHT_RST;
            r_level   <= gis_pkg::BINARIZE_LEVEL_RST;
            r_col     <= '0;
            r_row     <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                unique case (i_cfg_index)
                    gis_pkg::CFG_SOURCE_WIDTH:   r_src_w   <= i_cfg_data;
                    gis_pkg::CFG_SOURCE_HEIGHT:  r_src_h   <= i_cfg_data[gis_pkg::SIDE_W-1:0];
                    gis_pkg::CFG_SHOWN_WIDTH:    r_shown_w <= i_cfg_data[gis_pkg::SIDE_W-1:0];
                    gis_pkg::CFG_SHOWN_HEIGHT:   r_shown_h <= i_cfg_data[gis_pkg::SIDE_W-1:0];
                    gis_pkg::CFG_BINARIZE_LEVEL: r_level   <= i_cfg_data[gis_pkg::GRAY_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (i_cmd.capture) begin
                r_col <= n_col;
                r_row <= n_row;
            end
        end
    end

    gis_div u_div_row (
        .i_clk      (i_clk),
        .i_load     (i_cmd.capture),
        .i_step     (i_cmd.div_step),
        .i_dividend (w_row_prod),
        .i_divisor  (w_eff_h),
        .o_quotient (w_row_quo)
    );

    gis_div u_div_col (
        .i_clk      (i_clk),
        .i_load     (i_cmd.capture),
        .i_step     (i_cmd.div_step),
        .i_dividend (w_col_prod),
        .i_divisor  (w_eff_w),
        .o_quotient (w_col_quo)
    );

    assign w_addr_prod = gis_pkg::PROD_W'(w_row_quo[gis_pkg::ROWQ_W-1:0])
                       * gis_pkg::PROD_W'(r_src_w);
    assign w_wr_addr   = gis_pkg::ADDR_W'(i_s_tdata[gis_pkg::STORE_AW-1:0]);

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_last <= n_last;
        end
        if (i_cmd.addr_calc) begin
            r_addr <= gis_pkg::ADDR_W'(w_addr_prod)
                    + gis_pkg::ADDR_W'(w_col_quo[gis_pkg::COLQ_W-1:0]);
        end
        if (i_cmd.wr && (w_wr_addr < gis_pkg::ADDR_W'(STORE_DEPTH))) begin
            r_mem[w_wr_addr[MEM_AW-1:0]] <= i_s_tdata[gis_pkg::STORE_AW +: gis_pkg::GRAY_W];
        end
        if (i_cmd.mem_rd) begin
            r_rd_data <= r_mem[r_addr[MEM_AW-1:0]];
            r_rd_oob  <= (r_addr >= gis_pkg::ADDR_W'(STORE_DEPTH));
        end
        if (i_cmd.out_load) begin
            r_pixel     <= gis_pkg::to_color(r_rd_oob ? '0 : r_rd_data, r_level);
            r_frame_end <= r_last;
        end
    end

    assign o_m_tdata = r_pixel;
    assign o_m_tlast = r_frame_end;

    a_wrap_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.capture && n_last) |=> (r_col == '0 && r_row == '0))
        else $error("display counters did not wrap after the last pixel");

    a_last_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.out_load) |=> (r_frame_end == $past(r_last)))
        else $error("frame end flag lost between capture and output");

    a_no_write_in_fetch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.div_step || i_cmd.addr_calc || i_cmd.mem_rd) |-> !i_cmd.wr)
        else $error("frame store written while a fetch is in progress");

endmodule

### src/gis_ctrl.sv
`timescale 1ns / 1ps
// Controller of the gray image scaler: sequences one fetch through division,
// addressing, store read and output load, and owns the handshake flags. Depends on gis_pkg.
module gis_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    output logic             o_s_tready,
    output logic             o_m_tvalid,
    input  logic             i_m_tready,
    input  gis_pkg::t_dp_sts i_sts,
    output gis_pkg::t_dp_cmd o_cmd
);

    localparam int DIV_STEPS  = gis_pkg::DIVIDEND_W / gis_pkg::RADIX_BITS;
    localparam int STEP_CNT_W = $clog2(DIV_STEPS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_ADDR,
        S_READ,
        S_OUT
    } t_state;

    t_state                r_state;
    logic [STEP_CNT_W-1:0] r_step_cnt;
    logic                  r_out_valid;
    logic                  w_accept;
    logic                  w_out_free;

    assign o_s_tready = (r_state == S_IDLE);
    assign w_accept   = o_s_tready && i_s_tvalid;
    assign w_out_free = !r_out_valid || i_m_tready;
    assign o_m_tvalid = r_out_valid;

    always_comb begin
        o_cmd           = '0;
        o_cmd.wr        = w_accept && !i_sts.fetch_req;
        o_cmd.capture   = w_accept && i_sts.fetch_req;
        o_cmd.div_step  = (r_state == S_DIV);
        o_cmd.addr_calc = (r_state == S_ADDR);
        o_cmd.mem_rd    = (r_state == S_READ);
        o_cmd.out_load  = (r_state == S_OUT) && w_out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step_cnt  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (o_cmd.capture) begin
                        r_step_cnt <= '0;
                        r_state    <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_step_cnt <= r_step_cnt + STEP_CNT_W'(1);
                    if (r_step_cnt == STEP_CNT_W'(DIV_STEPS - 1)) begin
                        r_state <= S_ADDR;
                    end
                end
                S_ADDR: begin
                    r_state <= S_READ;
                end
                S_READ: begin
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_step_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_step_cnt < STEP_CNT_W'(DIV_STEPS)))
        else $error("divider step count ran past the last step");

    a_fetch_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_sts.fetch_req) |=> (r_state == S_DIV && r_step_cnt == '0))
        else $error("accepted fetch did not start the divider");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_m_tready) |-> !o_cmd.out_load)
        else $error("output register loaded while holding an untaken result");

endmodule

### src/gray_image_scaler_rgb565_top.sv
`timescale 1ns / 1ps
// Top level of the gray image scaler: nearest-neighbor scaling of a stored gray frame
// to RGB565 display pixels. Depends on gis_pkg, gis_ctrl, gis_datapath and gis_div.
//
//  Channel   Direction  Handshake                       Contents
//  s_axis    in         i_s_axis_tvalid/o_s_axis_tready tuser: req_type;
//                                                       tdata: store_address, gray_value
//  m_axis    out        o_m_axis_tvalid/i_m_axis_tready tdata: pixel_color; tlast: frame_end
//  cfg       in         i_cfg_wr_en                     i_cfg_index, i_cfg_data
//
// A write keeps the controller idle, so the next one is accepted in the following cycle.
// A fetch runs through a capture, nine steps of the two radix-4 divider lanes, address
// multiply, store read and output load before the next transaction is accepted.
// A result waiting in the output register does not block the next transaction; only the
// load of a further fetch result waits for it to be taken. Reset is synchronous, clears the
// counters and valid flag and loads the register defaults; the frame store is not cleared.
module gray_image_scaler_rgb565_top #(
    parameter int STORE_DEPTH    = gis_pkg::STORE_DEPTH_DEF,
    parameter int MAX_SHOWN_SIDE = gis_pkg::MAX_SHOWN_SIDE_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // Fields from bit 0: store_address[14:0], gray_value[22:15], zero pad[23].
    input  logic [gis_pkg::IN_TDATA_W-1:0]     i_s_axis_tdata,
    // Field: req_type.
    input  logic                               i_s_axis_tuser,
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // Field: pixel_color[15:0].
    output logic [gis_pkg::PIX_W-1:0]          o_m_axis_tdata,
    output logic                               o_m_axis_tlast,
    input  logic                               i_cfg_wr_en,
    input  logic [gis_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [gis_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    gis_pkg::t_dp_cmd w_cmd;
    gis_pkg::t_dp_sts w_sts;

    gis_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_axis_tvalid),
        .o_s_tready (o_s_axis_tready),
        .o_m_tvalid (o_m_axis_tvalid),
        .i_m_tready (i_m_axis_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    gis_datapath #(
        .STORE_DEPTH    (STORE_DEPTH),
        .MAX_SHOWN_SIDE (MAX_SHOWN_SIDE)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_s_tdata   (i_s_axis_tdata),
        .i_s_tuser   (i_s_axis_tuser),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_m_tdata   (o_m_axis_tdata),
        .o_m_tlast   (o_m_axis_tlast)
    );

endmodule

### sim/gray_image_scaler_rgb565_top_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench of gray_image_scaler_rgb565_top: a gray frame is loaded through
// write transactions and each fetch result is compared with a local scaling predictor.
// Depends on gis_pkg and the scaler RTL.
module gray_image_scaler_rgb565_top_tb;

    localparam int CYCLE_LIMIT   = 800000;
    localparam int SETTLE_CYCLES = 30;
    localparam int HOLD_OFF_LEN  = 600;

    typedef struct {
        logic [gis_pkg::PIX_W-1:0] pixel_color;
        logic                      frame_end;
    } t_pixel;

    logic                              i_clk;
    logic                              rst_n     = 1'b0;
    logic                              s_tvalid  = 1'b0;
    logic [gis_pkg::IN_TDATA_W-1:0]    s_tdata   = '0;
    logic                              s_tuser   = gis_pkg::REQ_WRITE;
    logic                              m_tready  = 1'b0;
    logic                              cfg_wr    = 1'b0;
    logic [gis_pkg::CFG_IDX_W-1:0]     cfg_index = '0;
    logic [gis_pkg::CFG_DATA_W-1:0]    cfg_data  = '0;
    wire                               s_tready;
    wire                               m_tvalid;
    wire  [gis_pkg::PIX_W-1:0]         m_tdata;
    wire                               m_tlast;

    logic [gis_pkg::GRAY_W-1:0] frame_copy[gis_pkg::STORE_DEPTH_DEF];
    bit                         written[gis_pkg::STORE_DEPTH_DEF];
    t_pixel                     expected_pixels[$];
    t_pixel                     want;

    int unsigned                src_width  = gis_pkg::SOURCE_WIDTH_RST;
    int unsigned                src_height = gis_pkg::SOURCE_HEIGHT_RST;
    int unsigned                shown_w    = gis_pkg::SHOWN_WIDTH_RST;
    int unsigned                shown_h    = gis_pkg::SHOWN_HEIGHT_RST;
    logic [gis_pkg::GRAY_W-1:0] level      = gis_pkg::BINARIZE_LEVEL_RST;
    logic [gis_pkg::SIDE_W-1:0] col_count  = '0;
    logic [gis_pkg::SIDE_W-1:0] row_count  = '0;

    int  send_idle_pct  = 0;
    int  recv_stall_pct = 0;
    logic hold_request  = 1'b0;
    int  hold_left      = 0;
    int  error_count    = 0;
    int  items_sent     = 0;
    int  writes_sent    = 0;
    int  pixels_checked = 0;
    int  frames_seen    = 0;
    int  settings_used  = 0;
    int  cycle_count    = 0;

    gray_image_scaler_rgb565_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tlast  (m_tlast),
        .i_cfg_wr_en     (cfg_wr),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // The receiver stalls at random and, on request, holds off for a long stretch.
    always @(posedge i_clk) begin
        if (hold_request) begin
            hold_request = 1'b0;
            hold_left = HOLD_OFF_LEN;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (rst_n && m_tvalid && m_tready) begin
            if (expected_pixels.size() == 0) begin
                $error("unexpected transaction: pixel_color %h frame_end %b", m_tdata, m_tlast);
                error_count++;
            end else begin
                want = expected_pixels.pop_front();
                if (m_tdata !== want.pixel_color) begin
                    $error("pixel_color expected %h actual %h", want.pixel_color, m_tdata);
                    error_count++;
                end
                if (m_tlast !== want.frame_end) begin
                    $error("frame_end expected %b actual %b", want.frame_end, m_tlast);
                    error_count++;
                end
                pixels_checked++;
                if (want.frame_end) frames_seen++;
            end
        end
    end

    function automatic int unsigned clamp_side(input int unsigned v);
        if (v == 0) return 1;
        if (v > gis_pkg::MAX_SHOWN_SIDE_DEF) return gis_pkg::MAX_SHOWN_SIDE_DEF;
        return v;
    endfunction

    function automatic int unsigned next_source_address();
        int unsigned r;
        int unsigned c;
        r = (row_count * src_height) / clamp_side(shown_h);
        c = (col_count * src_width) / clamp_side(shown_w);
        return r * src_width + c;
    endfunction

    function automatic logic [gis_pkg::PIX_W-1:0] gray_to_rgb565(
        input logic [gis_pkg::GRAY_W-1:0] g
    );
        if (level == '0) return {g[7:3], g[7:2], g[7:3]};
        return (g < level) ? gis_pkg::COLOR_BLACK : gis_pkg::COLOR_WHITE;
    endfunction

    task automatic predict_fetch();
        int unsigned                a;
        logic [gis_pkg::GRAY_W-1:0] g;
        t_pixel                     p;
        a = next_source_address();
        g = (a < gis_pkg::STORE_DEPTH_DEF) ? frame_copy[a] : '0;
        p.pixel_color = gray_to_rgb565(g);
        p.frame_end = 1'b0;
        if (col_count + 1 >= clamp_side(shown_w)) begin
            col_count = '0;
            if (row_count + 1 >= clamp_side(shown_h)) begin
                row_count = '0;
                p.frame_end = 1'b1;
            end else begin
                row_count = row_count + 1'b1;
            end
        end else begin
            col_count = col_count + 1'b1;
        end
        expected_pixels.push_back(p);
    endtask

    task automatic send_item(input logic kind, input logic [gis_pkg::STORE_AW-1:0] addr,
                             input logic [gis_pkg::GRAY_W-1:0] gray);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {1'b0, gray, addr};
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        items_sent++;
        if (kind == gis_pkg::REQ_WRITE) begin
            frame_copy[addr] = gray;
            written[addr] = 1'b1;
            writes_sent++;
        end else begin
            predict_fetch();
        end
    endtask

    task automatic send_fetch();
        send_item(gis_pkg::REQ_FETCH, gis_pkg::STORE_AW'($urandom),
                  gis_pkg::GRAY_W'($urandom));
    endtask

    // Writes the next fetch's source pixel first with the given value, if in the store.
    task automatic fetch_with_gray(input logic [gis_pkg::GRAY_W-1:0] g);
        int unsigned a;
        a = next_source_address();
        if (a < gis_pkg::STORE_DEPTH_DEF) begin
            send_item(gis_pkg::REQ_WRITE, gis_pkg::STORE_AW'(a), g);
        end
        send_fetch();
    endtask

    function automatic logic [gis_pkg::GRAY_W-1:0] pick_gray();
        int unsigned sel;
        sel = $urandom_range(3);
        if (level != '0 && sel == 0) return level;
        if (level != '0 && sel == 1) return level - 1'b1;
        return gis_pkg::GRAY_W'($urandom);
    endfunction

    task automatic fetch_pixel();
        int unsigned a;
        a = next_source_address();
        if (a < gis_pkg::STORE_DEPTH_DEF && !written[a]) begin
            send_item(gis_pkg::REQ_WRITE, gis_pkg::STORE_AW'(a), pick_gray());
        end
        send_fetch();
    endtask

    task automatic write_random_pixel();
        int unsigned region;
        region = src_width * src_height;
        if ($urandom_range(1) == 0 || region == 0 || region > gis_pkg::STORE_DEPTH_DEF)
            region = gis_pkg::STORE_DEPTH_DEF;
        send_item(gis_pkg::REQ_WRITE, gis_pkg::STORE_AW'($urandom_range(region - 1)),
                  gis_pkg::GRAY_W'($urandom));
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (expected_pixels.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apply_setting(input int unsigned sw, input int unsigned sh,
                                 input int unsigned dw, input int unsigned dh,
                                 input int unsigned lv);
        logic [gis_pkg::CFG_IDX_W-1:0]  idx[5];
        logic [gis_pkg::CFG_DATA_W-1:0] val[5];
        wait_idle();
        idx = '{gis_pkg::CFG_SOURCE_WIDTH, gis_pkg::CFG_SOURCE_HEIGHT,
                gis_pkg::CFG_SHOWN_WIDTH, gis_pkg::CFG_SHOWN_HEIGHT,
                gis_pkg::CFG_BINARIZE_LEVEL};
        val = '{gis_pkg::CFG_DATA_W'(sw), gis_pkg::CFG_DATA_W'(sh & 8'hff),
                gis_pkg::CFG_DATA_W'(dw & 8'hff), gis_pkg::CFG_DATA_W'(dh & 8'hff),
                gis_pkg::CFG_DATA_W'(lv & 8'hff)};
        for (int k = 0; k < 5; k++) begin
            cfg_wr    <= 1'b1;
            cfg_index <= idx[k];
            cfg_data  <= val[k];
            @(posedge i_clk);
        end
        // An index past the register list must leave every register unchanged.
        cfg_wr    <= 1'b1;
        cfg_index <= gis_pkg::CFG_IDX_W'($urandom_range(2 ** gis_pkg::CFG_IDX_W - 1,
                                                        gis_pkg::CFG_BINARIZE_LEVEL + 1));
        cfg_data  <= gis_pkg::CFG_DATA_W'($urandom);
        @(posedge i_clk);
        cfg_wr <= 1'b0;
        src_width  = val[0];
        src_height = val[1];
        shown_w    = val[2];
        shown_h    = val[3];
        level      = val[4][gis_pkg::GRAY_W-1:0];
        settings_used++;
    endtask

    task automatic random_setting();
        int unsigned sw;
        int unsigned sh;
        int unsigned dw;
        int unsigned dh;
        int unsigned lv;
        sw = ($urandom_range(7) == 0) ? $urandom_range(511) : $urandom_range(256, 1);
        sh = ($urandom_range(7) == 0) ? $urandom_range(255) : $urandom_range(128, 1);
        dw = ($urandom_range(7) == 0) ? $urandom_range(255) : $urandom_range(12, 1);
        dh = ($urandom_range(7) == 0) ? $urandom_range(255) : $urandom_range(8, 1);
        lv = ($urandom_range(1) == 0) ? 0 : $urandom_range(255, 1);
        apply_setting(sw, sh, dw, dh, lv);
    endtask

    task automatic test_reset_setting();
        send_item(gis_pkg::REQ_WRITE, '1, 8'hff);
        send_item(gis_pkg::REQ_WRITE, '1, 8'h00);
        fetch_with_gray(8'hff);
        fetch_with_gray(8'h00);
        fetch_with_gray(8'h5a);
    endtask

    // The column counter is left past the new shown width, then a frame completes.
    task automatic test_binarize_and_counter_wrap();
        apply_setting(4, 4, 2, 2, 128);
        fetch_with_gray(8'd127);
        fetch_with_gray(8'd128);
        fetch_with_gray(8'd255);
        fetch_with_gray(8'd0);
    endtask

    task automatic test_zero_sizes();
        apply_setting(0, 0, 0, 0, 1);
        fetch_with_gray(8'd0);
        fetch_with_gray(8'd1);
    endtask

    // A row counter beyond the shown height pushes the source address past the store.
    task automatic test_oversize_and_outside_store();
        apply_setting(511, 255, 1, 2, 0);
        fetch_with_gray(8'ha5);
        apply_setting(511, 255, 255, 1, 0);
        fetch_with_gray(8'h3c);
        fetch_with_gray(8'hc3);
    endtask

    task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                       input int n_items);
        int target;
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        for (int s = 0; s < 2; s++) begin
            random_setting();
            target = items_sent + n_items / 2;
            while (items_sent < target) begin
                if ($urandom_range(99) < 60) fetch_pixel();
                else write_random_pixel();
            end
        end
    endtask

    task automatic test_output_hold_off();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        apply_setting($urandom_range(40, 1), $urandom_range(30, 1), 5, 3, 0);
        hold_request = 1'b1;
        repeat (100) fetch_pixel();
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_setting();
        test_binarize_and_counter_wrap();
        test_zero_sizes();
        test_oversize_and_outside_store();
        test_random_traffic(0, 0, 440);
        test_random_traffic(74, 0, 440);
        test_random_traffic(0, 74, 440);
        test_random_traffic(20, 20, 440);
        test_output_hold_off();
        wait_idle();
        $display("Sent %0d transactions (%0d store writes) under %0d register settings.",
                 items_sent, writes_sent, settings_used);
        $display("Checked %0d pixels, %0d of them frame ends, with %0d mismatches.",
                 pixels_checked, frames_seen, error_count);
        if (error_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
